// File: hw/rtl/stil_pkg.sv
// Shared types and constants for the sorted table block.
`timescale 1ns / 1ps

package stil_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SEARCH,
        S_UPDATE
    } state_t;

    // per-cell control, driven by the sequencer each cycle
    typedef struct packed {
        logic cmp;    // capture compare flags against the request value
        logic shift;  // take the left neighbor's entry
        logic load;   // take the request value
    } cell_ctl_t;

endpackage

// File: hw/rtl/stil_req_if.sv
// Request channel: valid/ready handshake with mode and value.
`timescale 1ns / 1ps

interface stil_req_if
    import stil_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: hw/rtl/stil_res_if.sv
// Result channel: valid/ready handshake with position and status flags.
`timescale 1ns / 1ps

interface stil_res_if
    import stil_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic             found;
    logic             full_res;

    modport source (output valid, output position, output found, output full_res,
                    input ready);
    modport sink   (input valid, input position, input found, input full_res,
                    output ready);
endinterface

// File: hw/rtl/stil_cell.sv
// One table cell: holds an entry, compares it, and shifts from its left neighbor.
`timescale 1ns / 1ps

module stil_cell
    import stil_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [VALUE_W-1:0] value,
    input  logic [VALUE_W-1:0] left_data,
    output logic [VALUE_W-1:0] data,
    output logic               gt,
    output logic               lt
);

    logic [VALUE_W-1:0] data_reg;
    logic               gt_reg;
    logic               lt_reg;

    // entry is payload only; contents are undefined until written
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= value;
        end
        else if (ctl.shift)
        begin
            data_reg <= left_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
            lt_reg <= 1'b0;
        end
        else if (ctl.cmp)
        begin
            gt_reg <= (data_reg > value);
            lt_reg <= (data_reg < value);
        end
    end

    assign data = data_reg;
    assign gt   = gt_reg;
    assign lt   = lt_reg;

endmodule

// File: hw/rtl/sorted_table_insert_lookup.sv
// Top level: sorted table of cells with a binary search and shift-insert sequencer.
`timescale 1ns / 1ps

// Sorted table of CAPACITY unsigned 32-bit entries kept as a row of cells.
// A request (mode 0 insert, mode 1 lookup) is taken only when the sequencer is
// idle. It then passes through S_CMP, where every cell compares against the value,
// then S_SEARCH for the binary search probes (at most log2(CAPACITY)+1, read from
// the registered compare flags) and one closing step when the window closes
// without a hit, then S_UPDATE, which waits for a free result slot and, for an
// insert into a table that is not full, shifts the cells up and writes the new
// value. A new request is taken only once the last one has left S_UPDATE. A result
// waits in an output register; an insert into a full table is refused with
// full_res=1. No clearing pass.

module sorted_table_insert_lookup
    import stil_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    stil_req_if.sink    req,
    stil_res_if.source  res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

    state_t state_reg, state_next;

    logic [CW-1:0]        fill_reg, fill_next;
    logic signed [CW:0]   lo_reg, lo_next;
    logic signed [CW:0]   hi_reg, hi_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 hit_reg, hit_next;
    logic                 mode_reg;
    logic [VALUE_W-1:0]   value_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [POS_W-1:0]     out_pos_reg, out_pos_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_full_reg, out_full_next;

    cell_ctl_t            ctl [CAPACITY];
    logic [VALUE_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY-1:0]  gt_vec;
    logic [CAPACITY-1:0]  lt_vec;

    logic                 accept;
    logic                 slot_free;
    logic                 search_done;
    logic signed [CW+1:0] mid_sum;
    logic signed [CW:0]   mid;
    logic [IW-1:0]        mid_idx;
    logic                 table_full;
    logic [CW-1:0]        ins_pos;
    logic [CW-1:0]        ins_pos_raw;
    logic                 commit;
    logic                 do_write;
    logic [CW+POS_W-1:0]  pos_ext;

    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || res.ready;

    assign search_done = (lo_reg > hi_reg);
    assign mid_sum     = {lo_reg[CW], lo_reg} + {hi_reg[CW], hi_reg};
    assign mid         = mid_sum[CW+1:1];
    assign mid_idx     = mid[IW-1:0];

    assign table_full  = (fill_reg == CW'(CAPACITY));
    assign ins_pos_raw = hit_reg ? (pos_reg + CW'(1)) : pos_reg;
    assign ins_pos     = (ins_pos_raw > fill_reg) ? fill_reg : ins_pos_raw;

    assign commit   = (state_reg == S_UPDATE) && slot_free;
    assign do_write = commit && (mode_reg == MODE_INSERT) && !table_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (search_done || (!gt_vec[mid_idx] && !lt_vec[mid_idx]))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_pos_next   = out_pos_reg;
        out_found_next = out_found_reg;
        out_full_next  = out_full_reg;
        pos_ext        = '0;
        case (state_reg)
            S_IDLE:
            begin
                lo_next  = '0;
                hi_next  = $signed({1'b0, fill_reg}) - (CW+1)'(1);
                hit_next = 1'b0;
            end
            S_SEARCH:
            begin
                if (search_done)
                begin
                    pos_next = lo_reg[CW-1:0];
                    hit_next = 1'b0;
                end
                else if (gt_vec[mid_idx])
                begin
                    hi_next = mid - (CW+1)'(1);
                end
                else if (lt_vec[mid_idx])
                begin
                    lo_next = mid + (CW+1)'(1);
                end
                else
                begin
                    pos_next = mid[CW-1:0];
                    hit_next = 1'b1;
                end
            end
            S_UPDATE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_INSERT)
                    begin
                        pos_ext        = {{POS_W{1'b0}}, ins_pos};
                        out_found_next = 1'b0;
                        out_full_next  = table_full;
                        if (!table_full)
                        begin
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        pos_ext        = {{POS_W{1'b0}}, pos_reg};
                        out_found_next = hit_reg;
                        out_full_next  = 1'b0;
                    end
                    out_pos_next = pos_ext[POS_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // per-cell control: cells right of the insert point shift, the point loads
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctl[i].cmp   = (state_reg == S_CMP);
            ctl[i].shift = do_write && (CW'(i) > ins_pos) && (CW'(i) <= fill_reg);
            ctl[i].load  = do_write && (CW'(i) == ins_pos);
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VALUE_W-1:0] left;
            if (g == 0)
            begin : g_first
                assign left = value_reg;
            end
            else
            begin : g_rest
                assign left = cell_data[g-1];
            end
            stil_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[g]),
                .value     (value_reg),
                .left_data (left),
                .data      (cell_data[g]),
                .gt        (gt_vec[g]),
                .lt        (lt_vec[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.mode;
            value_reg <= req.value;
        end
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        pos_reg       <= pos_next;
        hit_reg       <= hit_next;
        out_pos_reg   <= out_pos_next;
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign res.valid    = out_valid_reg;
    assign res.position = out_pos_reg;
    assign res.found    = out_found_reg;
    assign res.full_res = out_full_reg;

`ifndef SYNTHESIS
    // fill count only ever grows by one, on a committed insert
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |->
            (fill_reg == $past(fill_reg) + CW'(1)) && ($past(state_reg) == S_UPDATE))
        else $error("fill count changed outside an insert");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // search low bound never leaves the range from zero to the fill count
    a_lo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg >= 0) && (lo_reg <= $signed({1'b0, fill_reg})))
        else $error("search low bound out of range");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_UPDATE))
        else $error("result raised outside the update step");
`endif

endmodule

// File: tb/tb_sorted_table_insert_lookup.sv
// Testbench for the sorted table block: insert and lookup traffic checked against a shadow table.
`timescale 1ns / 1ps

module tb_sorted_table_insert_lookup;
    import stil_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 1680;
    localparam int MAX_GAP       = 13;
    localparam int LONG_HOLD     = 240;
    localparam int HOLD_AT       = 300;
    localparam int DRAIN_AT      = 900;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
        logic             full_res;
    } answer_t;

    // Shadow copy of the table plus the queue of answers still owed by the block.
    class sorted_table_scoreboard;
        bit [VALUE_W-1:0] shadow_vals[TABLE_DEPTH];
        int               shadow_count;
        answer_t          pending_answers[$];
        int               errors;

        function new();
            shadow_count = 0;
            errors       = 0;
        endfunction

        task report_mismatch(input string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        // Binary search with midpoint (lo+hi)>>1, stopping at the first equal probe.
        function void probe_search(input bit [VALUE_W-1:0] v, output bit hit, output int pos);
            int lo;
            int hi;
            int mid;
            lo  = 0;
            hi  = shadow_count - 1;
            hit = 1'b0;
            pos = 0;
            while (lo <= hi)
            begin
                mid = (lo + hi) >> 1;
                if (shadow_vals[mid] > v)
                    hi = mid - 1;
                else if (shadow_vals[mid] < v)
                    lo = mid + 1;
                else
                begin
                    hit = 1'b1;
                    pos = mid;
                    return;
                end
            end
            pos = lo;
        endfunction

        function void note_request(input logic mode, input logic [VALUE_W-1:0] v);
            bit      hit;
            int      pos;
            answer_t ans;
            probe_search(v, hit, pos);
            ans = '0;
            if (mode == MODE_INSERT)
            begin
                if (hit)
                    pos++;
                if (pos > shadow_count)
                    pos = shadow_count;
                if (shadow_count >= TABLE_DEPTH)
                    ans.full_res = 1'b1;
                else
                begin
                    for (int j = shadow_count; j > pos; j--)
                        shadow_vals[j] = shadow_vals[j-1];
                    shadow_vals[pos] = v;
                    shadow_count++;
                end
            end
            else
                ans.found = hit;
            ans.position = pos[POS_W-1:0];
            pending_answers.push_back(ans);
        endfunction

        task check_result(input logic [POS_W-1:0] position, input logic found,
                          input logic full_res);
            answer_t want;
            if (pending_answers.size() == 0)
            begin
                report_mismatch($sformatf("result pos=%0d with no request pending", position));
                return;
            end
            want = pending_answers.pop_front();
            if (position !== want.position)
                report_mismatch($sformatf("position %0d, expected %0d", position, want.position));
            if (found !== want.found)
                report_mismatch($sformatf("found %b, expected %b", found, want.found));
            if (full_res !== want.full_res)
                report_mismatch($sformatf("full_res %b, expected %b", full_res, want.full_res));
        endtask

        task flag_leftovers();
            while (pending_answers.size() != 0)
            begin
                void'(pending_answers.pop_front());
                report_mismatch("request never answered");
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    stil_req_if req_ch();
    stil_res_if res_ch();

    sorted_table_insert_lookup #(.CAPACITY(TABLE_DEPTH)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .res   (res_ch.source)
    );

    sorted_table_scoreboard sb;
    bit send_calm;
    bit recv_calm;
    int results_taken;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Calm stretches have no gaps; otherwise each item gets a random gap.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 29) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_insert_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, 24);
            5:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            6: v = {3'($urandom_range(0, 7)), 29'd0};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Lookups mostly aim at stored values or their neighbors so that hits are common.
    function automatic logic [VALUE_W-1:0] pick_lookup_value();
        logic [VALUE_W-1:0] v;
        int                 sel;
        sel = $urandom_range(0, 9);
        if (sb.shadow_count == 0 || sel > 5)
            v = pick_insert_value();
        else
        begin
            v = sb.shadow_vals[$urandom_range(0, sb.shadow_count - 1)];
            if (sel == 4)
                v = v + 1;
            else if (sel == 5)
                v = v - 1;
        end
        return v;
    endfunction

    task send_request(input logic mode, input logic [VALUE_W-1:0] v);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(mode, v);
    endtask

    task wait_for_drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_answers.size() != 0);
    endtask

    // Result side: random stalls, plus one long hold so the block backs up.
    initial
    begin
        int gap;
        res_ch.ready  <= 1'b0;
        results_taken = 0;
        @(posedge clk);
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = (results_taken == HOLD_AT) ? LONG_HOLD : draw_gap(recv_calm);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
            sb.check_result(res_ch.position, res_ch.found, res_ch.full_res);
            results_taken++;
        end
    end

    initial
    begin
        logic mode;
        sb = new();
        send_calm = 1'b0;
        recv_calm = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= MODE_LOOKUP;
        req_ch.value <= '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, duplicates, extremes, misses between entries
        send_request(MODE_LOOKUP, 32'h0000_0000);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'd5);
        send_request(MODE_INSERT, 32'd5);
        send_request(MODE_INSERT, 32'd5);
        send_request(MODE_LOOKUP, 32'd5);
        send_request(MODE_LOOKUP, 32'd4);
        send_request(MODE_LOOKUP, 32'd6);
        send_request(MODE_INSERT, 32'h0000_0000);
        send_request(MODE_INSERT, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, 32'h0000_0000);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'd3);
        send_request(MODE_INSERT, 32'd7);
        send_request(MODE_LOOKUP, 32'd7);
        send_request(MODE_INSERT, 32'h8000_0000);
        send_request(MODE_LOOKUP, 32'h7FFF_FFFF);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == DRAIN_AT)
                wait_for_drain();
            // fill slowly so lookups see many table sizes; refused inserts once full
            if (sb.shadow_count < TABLE_DEPTH)
                mode = ($urandom_range(0, 4) == 0) ? MODE_INSERT : MODE_LOOKUP;
            else
                mode = ($urandom_range(0, 9) == 0) ? MODE_INSERT : MODE_LOOKUP;
            send_request(mode, (mode == MODE_INSERT) ? pick_insert_value()
                                                     : pick_lookup_value());
        end

        // full table: refused inserts at the extremes and on a stored value
        send_request(MODE_INSERT, 32'h0000_0000);
        send_request(MODE_INSERT, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, sb.shadow_vals[TABLE_DEPTH/2]);
        send_request(MODE_LOOKUP, 32'h0000_0000);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
